// ===== hw/rtl/multiplexed_segment_display_scanner_top_assert.svh =====
// Assertion macros for the segment display scanner.
// Needs clk and rst in the scope of each use.
`ifndef MULTIPLEXED_SEGMENT_DISPLAY_SCANNER_TOP_ASSERT_SVH
`define MULTIPLEXED_SEGMENT_DISPLAY_SCANNER_TOP_ASSERT_SVH

// same-cycle implication
`define MSDS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("msds assertion failed");

// next-cycle implication
`define MSDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("msds assertion failed");

`endif

// ===== hw/rtl/msds_pkg.sv =====
// Package for the segment display scanner: chain codes, queue entry type,
// and the logical-to-wiring segment permutation. No dependencies.
package msds_pkg;

  localparam int DIGIT_COUNT_DEFAULT = 13;
  localparam int SEG_BITS = 16;
  localparam int MASK_BITS = 13;
  localparam int DIGIT_W = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] CHAIN_DIGIT   = 2'd0;
  localparam logic [1:0] CHAIN_SEGMENT = 2'd1;
  localparam logic [1:0] CHAIN_LATCH   = 2'd2;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [3:0] WIRING_BIT [SEG_BITS] = '{
    4'd8, 4'd0, 4'd2, 4'd5, 4'd6, 4'd7, 4'd14, 4'd10,
    4'd9, 4'd15, 4'd1, 4'd3, 4'd4, 4'd12, 4'd13, 4'd11
  };

  typedef struct packed {
    logic [DIGIT_W-1:0]  digit;
    logic [SEG_BITS-1:0] word;
    logic                dp_off;
  } tick_t;

  typedef struct packed {
    logic  valid;
    tick_t data;
  } q_port_t;

  function automatic logic [SEG_BITS-1:0] to_wiring_active_low(
      input logic [SEG_BITS-1:0] logical);
    logic [SEG_BITS-1:0] wired;
    wired = '0;
    for (int i = 0; i < SEG_BITS; i++) begin
      if (logical[i]) begin
        wired[WIRING_BIT[i]] = 1'b1;
      end
    end
    return ~wired;
  endfunction

endpackage

// ===== hw/rtl/multiplexed_segment_display_scanner_top.sv =====
// Scan driver for multiplexed 16-segment digits: top level.
// Depends on msds_pkg, msds_front, msds_queue, msds_back and the assert header.
//
// Input channel (in_valid/in_ready): func 1 writes logical_segments for digit
// write_digit (ignored when write_digit >= DIGIT_COUNT) and yields no result;
// func 0 is a refresh tick that yields DIGIT_COUNT + 17 results (30 by
// default): digit-chain bits, segment-chain bits MSB first, then the latch
// result with last set. cfg_we/cfg_wdata write the decimal point mask.
// Output channel (out_valid/out_ready): one result per transfer, at most one
// per cycle. A tick's results pass through the queue, the back end's entry
// register and the output register. The back end emits one result per cycle
// while out_ready holds; a two-entry queue lets the front accept writes and
// up to two ticks ahead while results drain.
// A stalled receiver holds the output register; the queue fills and then
// in_ready drops. Reset (rst, synchronous) sets all segments off, the mask
// and scan digit to zero, and empties the queue.
module multiplexed_segment_display_scanner_top #(
  parameter int DIGIT_COUNT = msds_pkg::DIGIT_COUNT_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 func,
  input  logic [msds_pkg::DIGIT_W-1:0]         write_digit,
  input  logic [msds_pkg::SEG_BITS-1:0]        logical_segments,
  input  logic                                 cfg_we,
  input  logic [msds_pkg::MASK_BITS-1:0]       cfg_wdata,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           chain,
  output logic                                 serial_bit,
  output logic [msds_pkg::DIGIT_W-1:0]         digit_index,
  output logic                                 decimal_point_off,
  output logic                                 last
);
  import msds_pkg::*;

`include "multiplexed_segment_display_scanner_top_assert.svh"

  q_port_t push;
  q_port_t head;
  logic    q_full;
  logic    pop;

  msds_front #(.DIGIT_COUNT(DIGIT_COUNT)) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .write_digit      (write_digit),
    .logical_segments (logical_segments),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .q_full           (q_full),
    .push             (push)
  );

  msds_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  msds_back #(.DIGIT_COUNT(DIGIT_COUNT)) u_back (
    .clk               (clk),
    .rst               (rst),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .chain             (chain),
    .serial_bit        (serial_bit),
    .digit_index       (digit_index),
    .decimal_point_off (decimal_point_off),
    .last              (last)
  );

  `MSDS_ASSERT_NOW(a_last_is_latch, out_valid && last, chain == CHAIN_LATCH)
  `MSDS_ASSERT_NOW(a_shift_fields, out_valid && (chain != CHAIN_LATCH),
                   !last && !decimal_point_off)
  `MSDS_ASSERT_NOW(a_digit_range, out_valid, {1'b0, digit_index} < 5'(DIGIT_COUNT))
  `MSDS_ASSERT_NEXT(a_latch_no_bit, out_valid && last && !out_ready,
                    out_valid && !serial_bit)

endmodule

// ===== hw/rtl/msds_front.sv =====
// Front end: accepts items, updates the segment store on writes and turns
// each tick into a queue entry. Depends on msds_pkg.
module msds_front #(
  parameter int DIGIT_COUNT = msds_pkg::DIGIT_COUNT_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 func,
  input  logic [msds_pkg::DIGIT_W-1:0]         write_digit,
  input  logic [msds_pkg::SEG_BITS-1:0]        logical_segments,
  input  logic                                 cfg_we,
  input  logic [msds_pkg::MASK_BITS-1:0]       cfg_wdata,
  input  logic                                 q_full,
  output msds_pkg::q_port_t                    push
);
  import msds_pkg::*;

  localparam int IdxW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic [SEG_BITS-1:0]  store [DIGIT_COUNT];
  logic [DIGIT_W-1:0]   scan_digit;
  logic [MASK_BITS-1:0] mask;
  logic                 xfer;
  logic                 wr_ok;
  logic [15:0]          mask_ext;

  assign in_ready = !q_full;
  assign xfer     = in_valid && in_ready;
  assign wr_ok    = {1'b0, write_digit} < 5'(DIGIT_COUNT);
  assign mask_ext = 16'(mask);

  always_comb begin
    push.valid       = xfer && (func == FUNC_TICK);
    push.data.digit  = scan_digit;
    push.data.word   = store[scan_digit[IdxW-1:0]];
    push.data.dp_off = !((scan_digit < 4'(MASK_BITS)) && mask_ext[scan_digit]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        store[i] <= '1;
      end
      scan_digit <= '0;
      mask       <= '0;
    end else begin
      if (cfg_we) begin
        mask <= cfg_wdata;
      end
      if (xfer && (func == FUNC_WRITE) && wr_ok) begin
        store[write_digit[IdxW-1:0]] <= to_wiring_active_low(logical_segments);
      end
      if (xfer && (func == FUNC_TICK)) begin
        if (scan_digit == 4'(DIGIT_COUNT - 1)) begin
          scan_digit <= '0;
        end else begin
          scan_digit <= scan_digit + 4'd1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/msds_queue.sv =====
// Short queue of tick entries between front and back end.
// Depends on msds_pkg.
module msds_queue (
  input  logic              clk,
  input  logic              rst,
  input  msds_pkg::q_port_t push,
  input  logic              pop,
  output logic              full,
  output msds_pkg::q_port_t head
);
  import msds_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  tick_t            mem [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [PtrW:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full      = count == (PtrW+1)'(QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.data  = mem[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PtrW+1)'(1);
      end else if (!do_push && do_pop) begin
        count <= count - (PtrW+1)'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/msds_back.sv =====
// Back end: serializes one tick entry into its result sequence through an
// output register. Depends on msds_pkg.
module msds_back #(
  parameter int DIGIT_COUNT = msds_pkg::DIGIT_COUNT_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  msds_pkg::q_port_t             head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    chain,
  output logic                          serial_bit,
  output logic [msds_pkg::DIGIT_W-1:0]  digit_index,
  output logic                          decimal_point_off,
  output logic                          last
);
  import msds_pkg::*;

  localparam int NumRes = DIGIT_COUNT + SEG_BITS + 1;
  localparam int CntW   = $clog2(NumRes);

  logic            active;
  logic [CntW-1:0] cnt;
  tick_t           cur;
  logic            advance;
  logic            at_end;
  logic [CntW-1:0] seg_sel;
  logic [1:0]      r_chain;
  logic            r_bit;
  logic            r_dp;
  logic            r_last;

  assign advance = !out_valid || out_ready;
  assign at_end  = cnt == CntW'(NumRes - 1);
  assign pop     = head.valid && (!active || (advance && at_end));
  assign seg_sel = cnt - CntW'(DIGIT_COUNT);

  always_comb begin
    r_dp   = 1'b0;
    r_last = 1'b0;
    if (cnt < CntW'(DIGIT_COUNT)) begin
      r_chain = CHAIN_DIGIT;
      r_bit   = (CntW'(DIGIT_COUNT - 1) - cnt) == CntW'(cur.digit);
    end else if (cnt < CntW'(DIGIT_COUNT + SEG_BITS)) begin
      r_chain = CHAIN_SEGMENT;
      r_bit   = cur.word[4'(SEG_BITS - 1) - seg_sel[3:0]];
    end else begin
      r_chain = CHAIN_LATCH;
      r_bit   = 1'b0;
      r_dp    = cur.dp_off;
      r_last  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && active) begin
      chain             <= r_chain;
      serial_bit        <= r_bit;
      digit_index       <= cur.digit;
      decimal_point_off <= r_dp;
      last              <= r_last;
    end
    if (pop) begin
      cur <= head.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= active;
      end
      if (!active) begin
        if (head.valid) begin
          active <= 1'b1;
          cnt    <= '0;
        end
      end else if (advance) begin
        if (at_end) begin
          cnt    <= '0;
          active <= head.valid;
        end else begin
          cnt <= cnt + CntW'(1);
        end
      end
    end
  end

endmodule
